@@ design/qss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qss_pkg;

  // Default configuration of the sorter
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PORT_WIDTH      = 32;

  // Microprogram step addresses
  typedef enum logic [4:0] {
    U_IDLE     = 5'd0,
    U_INIT     = 5'd1,
    U_POP      = 5'd2,
    U_POP_D    = 5'd3,
    U_RD_PIV   = 5'd4,
    U_SET_PIV  = 5'd5,
    U_SCAN_IR  = 5'd6,
    U_SCAN_IC  = 5'd7,
    U_SCAN_JR  = 5'd8,
    U_SCAN_JC  = 5'd9,
    U_CHK      = 5'd10,
    U_SWAP1    = 5'd11,
    U_SWAP2    = 5'd12,
    U_FIN1     = 5'd13,
    U_FIN2     = 5'd14,
    U_PUSH_L   = 5'd15,
    U_PUSH_R   = 5'd16,
    U_OUT_INIT = 5'd17,
    U_OUT_RD   = 5'd18,
    U_OUT_LD   = 5'd19,
    U_OUT_NEXT = 5'd20,
    U_DONE     = 5'd21
  } ustep_t;

  // Datapath operation of one step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_PUSH,
    OP_POP,
    OP_TAKE_RANGE,
    OP_RD_LO,
    OP_SET_PIV,
    OP_RD_I,
    OP_CMP_I,
    OP_RD_J,
    OP_CMP_J,
    OP_WR_I,
    OP_WR_J,
    OP_WR_LO,
    OP_WR_PIV,
    OP_PUSH_L,
    OP_PUSH_R,
    OP_K_CLR,
    OP_RD_K,
    OP_OUT,
    OP_K_INC,
    OP_CLEAR
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_LAST,
    C_SP_ZERO,
    C_RANGE_BAD,
    C_I_PAST,
    C_LE_PIV,
    C_J_AT_LO,
    C_GT_PIV,
    C_I_GE_J,
    C_OUT_BUSY,
    C_K_LAST
  } cond_t;

  // One control word: operation, jump condition (optionally inverted), jump target
  typedef struct packed {
    op_t    op;
    cond_t  cond;
    logic   inv;
    ustep_t target;
  } ucw_t;

  // Control store. A step jumps to target when condition XOR inv holds, else to next step.
  function automatic ucw_t ucode(input ustep_t s);
    ucw_t w;
    case (s)
      U_IDLE:     w = '{OP_LOAD,       C_LAST,      1'b1, U_IDLE};
      U_INIT:     w = '{OP_INIT_PUSH,  C_ALWAYS,    1'b1, U_IDLE};
      U_POP:      w = '{OP_POP,        C_SP_ZERO,   1'b0, U_OUT_INIT};
      U_POP_D:    w = '{OP_TAKE_RANGE, C_RANGE_BAD, 1'b0, U_POP};
      U_RD_PIV:   w = '{OP_RD_LO,      C_ALWAYS,    1'b1, U_IDLE};
      U_SET_PIV:  w = '{OP_SET_PIV,    C_ALWAYS,    1'b1, U_IDLE};
      U_SCAN_IR:  w = '{OP_RD_I,       C_I_PAST,    1'b0, U_SCAN_JR};
      U_SCAN_IC:  w = '{OP_CMP_I,      C_LE_PIV,    1'b0, U_SCAN_IR};
      U_SCAN_JR:  w = '{OP_RD_J,       C_J_AT_LO,   1'b0, U_CHK};
      U_SCAN_JC:  w = '{OP_CMP_J,      C_GT_PIV,    1'b0, U_SCAN_JR};
      U_CHK:      w = '{OP_NONE,       C_I_GE_J,    1'b0, U_FIN1};
      U_SWAP1:    w = '{OP_WR_I,       C_ALWAYS,    1'b1, U_IDLE};
      U_SWAP2:    w = '{OP_WR_J,       C_ALWAYS,    1'b0, U_SCAN_IR};
      U_FIN1:     w = '{OP_WR_LO,      C_ALWAYS,    1'b1, U_IDLE};
      U_FIN2:     w = '{OP_WR_PIV,     C_ALWAYS,    1'b1, U_IDLE};
      U_PUSH_L:   w = '{OP_PUSH_L,     C_ALWAYS,    1'b1, U_IDLE};
      U_PUSH_R:   w = '{OP_PUSH_R,     C_ALWAYS,    1'b0, U_POP};
      U_OUT_INIT: w = '{OP_K_CLR,      C_ALWAYS,    1'b1, U_IDLE};
      U_OUT_RD:   w = '{OP_RD_K,       C_ALWAYS,    1'b1, U_IDLE};
      U_OUT_LD:   w = '{OP_OUT,        C_OUT_BUSY,  1'b0, U_OUT_LD};
      U_OUT_NEXT: w = '{OP_K_INC,      C_K_LAST,    1'b1, U_OUT_RD};
      U_DONE:     w = '{OP_CLEAR,      C_ALWAYS,    1'b0, U_IDLE};
      default:    w = '{OP_NONE,       C_ALWAYS,    1'b0, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/quicksort_sorter_unit.sv @@
// Load: one transaction per cycle; in_stall is low only while waiting for input.
// Sort: each scan step reads an element and then compares it with the pivot, and a swap
// writes both elements in turn; ordered or all-equal sets are the slow case.
// Output: read, load and advance per result; load waits while the held result is stalled.
// Reset (rst_n low, synchronous): element count, range stack pointer, overflow flag
// and output valid cleared; the sequencer returns to the idle step.
`timescale 1ns / 1ps
`default_nettype none

module quicksort_sorter_unit
  import qss_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [PORT_WIDTH-1:0] in_value,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [PORT_WIDTH-1:0]      out_value,
  output logic                              out_last,
  output logic                              out_overflow
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (VALUE_WIDTH > PORT_WIDTH) ? PORT_WIDTH : VALUE_WIDTH;

  // Memories: element store and range stack
  logic signed [SW-1:0] mem [CAPACITY];
  logic [2*IW-1:0]      stk [CAPACITY];

  // Sequencer and datapath registers
  ustep_t               upc_r, upc_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        sp_r, sp_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IW-1:0]        lo_r, lo_nxt;
  logic [IW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic signed [SW-1:0] piv_r, piv_nxt;
  logic signed [SW-1:0] vi_r, vi_nxt;
  logic signed [SW-1:0] vj_r, vj_nxt;
  logic signed [SW-1:0] rd_q;
  logic [2*IW-1:0]      stk_q;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_val_r, out_val_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // Memory port controls
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_wa, mem_ra;
  logic signed [SW-1:0] mem_wd;
  logic                 stk_we, stk_re;
  logic [IW-1:0]        stk_wa, stk_ra;
  logic [2*IW-1:0]      stk_wd;

  ucw_t          uw;
  logic          cond_hit, take;
  logic [IW-1:0] stk_lo, stk_hi;
  logic [CW-1:0] sp_dec;
  logic          le_piv, out_busy, k_last, push_room;

  assign uw        = ucode(upc_r);
  assign stk_lo    = stk_q[2*IW-1:IW];
  assign stk_hi    = stk_q[IW-1:0];
  assign sp_dec    = sp_r - CW'(1);
  assign le_piv    = (rd_q <= piv_r);
  assign out_busy  = out_valid_r && out_stall;
  assign k_last    = (CW'(k_r) == cnt_r - CW'(1));
  assign push_room = (sp_r < CW'(CAPACITY));

  // Jump condition select
  always_comb begin
    case (uw.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_LAST:      cond_hit = in_valid && in_last;
      C_SP_ZERO:   cond_hit = (sp_r == '0);
      C_RANGE_BAD: cond_hit = (CW'(stk_hi) >= cnt_r) || (stk_lo >= stk_hi);
      C_I_PAST:    cond_hit = (i_r > CW'(hi_r));
      C_LE_PIV:    cond_hit = le_piv;
      C_J_AT_LO:   cond_hit = (j_r == lo_r);
      C_GT_PIV:    cond_hit = !le_piv;
      C_I_GE_J:    cond_hit = (i_r >= CW'(j_r));
      C_OUT_BUSY:  cond_hit = out_busy;
      C_K_LAST:    cond_hit = k_last;
      default:     cond_hit = 1'b0;
    endcase
  end

  assign take = cond_hit ^ uw.inv;

  // Datapath: decode of the current control word
  always_comb begin
    upc_nxt       = take ? uw.target : ustep_t'(upc_r + 5'd1);
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    piv_nxt       = piv_r;
    vi_nxt        = vi_r;
    vj_nxt        = vj_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = vj_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    stk_we        = 1'b0;
    stk_wa        = sp_r[IW-1:0];
    stk_wd        = '0;
    stk_re        = 1'b0;
    stk_ra        = sp_dec[IW-1:0];

    case (uw.op)
      OP_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(CAPACITY)) begin
            mem_we  = 1'b1;
            mem_wa  = cnt_r[IW-1:0];
            mem_wd  = in_value[SW-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_INIT_PUSH: begin
        if (cnt_r > CW'(1) && push_room) begin
          stk_we = 1'b1;
          stk_wd = {IW'(0), IW'(cnt_r - CW'(1))};
          sp_nxt = sp_r + CW'(1);
        end
      end
      OP_POP: begin
        if (sp_r != '0) begin
          stk_re = 1'b1;
          sp_nxt = sp_dec;
        end
      end
      OP_TAKE_RANGE: begin
        lo_nxt = stk_lo;
        hi_nxt = stk_hi;
        i_nxt  = CW'(stk_lo) + CW'(1);
        j_nxt  = stk_hi;
      end
      OP_RD_LO: begin
        mem_re = 1'b1;
        mem_ra = lo_r;
      end
      OP_SET_PIV: piv_nxt = rd_q;
      OP_RD_I: begin
        mem_re = 1'b1;
        mem_ra = i_r[IW-1:0];
      end
      OP_CMP_I: begin
        if (le_piv) i_nxt = i_r + CW'(1);
        else vi_nxt = rd_q;
      end
      OP_RD_J: begin
        mem_re = 1'b1;
        mem_ra = j_r;
      end
      OP_CMP_J: begin
        if (!le_piv) j_nxt = j_r - IW'(1);
        else vj_nxt = rd_q;
      end
      OP_WR_I: begin
        mem_we = 1'b1;
        mem_wa = i_r[IW-1:0];
        mem_wd = vj_r;
      end
      OP_WR_J: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = vi_r;
      end
      OP_WR_LO: begin
        // when j stayed at lo this write is undone by the pivot write
        mem_we = 1'b1;
        mem_wa = lo_r;
        mem_wd = vj_r;
      end
      OP_WR_PIV: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = piv_r;
      end
      OP_PUSH_L: begin
        if (CW'(j_r) > CW'(lo_r) + CW'(1) && push_room) begin
          stk_we = 1'b1;
          stk_wd = {lo_r, j_r - IW'(1)};
          sp_nxt = sp_r + CW'(1);
        end
      end
      OP_PUSH_R: begin
        if (CW'(j_r) + CW'(1) < CW'(hi_r) && push_room) begin
          stk_we = 1'b1;
          stk_wd = {j_r + IW'(1), hi_r};
          sp_nxt = sp_r + CW'(1);
        end
      end
      OP_K_CLR: k_nxt = '0;
      OP_RD_K: begin
        mem_re = 1'b1;
        mem_ra = k_r;
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = rd_q;
          out_last_nxt  = k_last;
          out_ovf_nxt   = ovf_r;
        end
      end
      OP_K_INC: k_nxt = k_r + IW'(1);
      OP_CLEAR: begin
        cnt_nxt = '0;
        sp_nxt  = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      cnt_r       <= '0;
      sp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      sp_r        <= sp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    piv_r      <= piv_nxt;
    vi_r       <= vi_nxt;
    vj_r       <= vj_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Element store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // Range stack, registered read
  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    if (stk_re) stk_q <= stk[stk_ra];
  end

  // Ports
  assign in_stall     = (upc_r != U_IDLE);
  assign out_valid    = out_valid_r;
  assign out_value    = PORT_WIDTH'(out_val_r);
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

`default_nettype wire

@@ test/quicksort_sorter_unit_tb.sv @@
`timescale 1ns / 1ps

module quicksort_sorter_unit_tb
  import qss_pkg::*;
();

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [PORT_WIDTH-1:0] elem_t;

  // Shape of the values inside one generated set
  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_DUPS,
    SHAPE_RISING,
    SHAPE_FALLING
  } set_shape_t;

  typedef struct {
    elem_t value;
    logic  last;
  } load_item_t;

  typedef struct {
    elem_t value;
    logic  last;
    logic  ovf;
  } sorted_elem_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  elem_t in_value  = '0;
  logic  in_last   = 1'b0;
  logic  out_stall = 1'b0;

  logic  in_stall;
  logic  out_valid;
  elem_t out_value;
  logic  out_last;
  logic  out_overflow;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  quicksort_sorter_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Pending loads, expected sorted output, run bookkeeping
  load_item_t   load_queue[$];
  sorted_elem_t sorted_pending[$];
  load_item_t   next_load;
  sorted_elem_t want;

  int send_idle_pct  = 16;
  int recv_stall_pct = 49;
  int loads_queued   = 0;
  int loads_accepted = 0;
  int results_seen   = 0;
  int errors         = 0;
  int sets_done      = 0;
  int overflow_sets  = 0;
  int largest_set    = 0;
  int quiet_cycles   = 0;
  bit running        = 1'b0;

  // Sorter state as the block should hold it
  elem_t held_values[CAPACITY_DEF];
  int    held_count  = 0;
  logic  dropped_any = 1'b0;

  // Store one accepted element; a last-marked one sorts the set and queues the results
  function void absorb_element(input elem_t v, input logic last);
    elem_t        key;
    int           j;
    sorted_elem_t r;
    if (held_count < CAPACITY_DEF) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!last) return;
    // insertion sort, ascending signed
    for (int i = 1; i < held_count; i++) begin
      key = held_values[i];
      j = i - 1;
      while (j >= 0 && held_values[j] > key) begin
        held_values[j + 1] = held_values[j];
        j--;
      end
      held_values[j + 1] = key;
    end
    for (int k = 0; k < held_count; k++) begin
      r.value = held_values[k];
      r.last  = (k == held_count - 1);
      r.ovf   = dropped_any;
      sorted_pending.push_back(r);
    end
    sets_done++;
    if (dropped_any) overflow_sets++;
    if (held_count > largest_set) largest_set = held_count;
    held_count  = 0;
    dropped_any = 1'b0;
  endfunction

  // Input driver: present the next load once the current transaction is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        absorb_element(in_value, in_last);
        loads_accepted++;
      end
      if (!in_valid || in_fire) begin
        if (load_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_load = load_queue.pop_front();
          in_valid <= 1'b1;
          in_value <= next_load.value;
          in_last  <= next_load.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stall, compare each transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (out_fire) begin
        results_seen++;
        if (sorted_pending.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] unexpected result: value=%0d last=%b overflow=%b",
                     $realtime, out_value, out_last, out_overflow);
        end else begin
          want = sorted_pending.pop_front();
          if (out_value !== want.value || out_last !== want.last ||
              out_overflow !== want.ovf) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"[%0t] mismatch: exp value=%0d last=%b ovf=%b,",
                        " got value=%0d last=%b ovf=%b"},
                       $realtime, want.value, want.last, want.ovf,
                       out_value, out_last, out_overflow);
          end
        end
      end
    end
  end

  // Watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (!running || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, sorted_pending.size());
        $display("quicksort_sorter_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic push_item(input elem_t v, input logic last);
    load_item_t it;
    it.value = v;
    it.last  = last;
    load_queue.push_back(it);
    loads_queued++;
  endtask

  task automatic queue_set(input int n, input set_shape_t shape);
    elem_t base;
    int    stride;
    elem_t v;
    base   = $urandom;
    stride = $urandom_range(0, 1000);
    for (int k = 0; k < n; k++) begin
      case (shape)
        SHAPE_RANDOM:  v = $urandom;
        SHAPE_DUPS:    v = $urandom_range(0, 6) - 3;
        SHAPE_RISING:  v = base + k * stride;
        SHAPE_FALLING: v = base - k * stride;
        default:       v = '0;
      endcase
      push_item(v, k == n - 1);
    end
  endtask

  // One big set first, then mostly small sets until the load count is reached
  task automatic random_sets(input int target, input int first_size);
    int n;
    queue_set(first_size, set_shape_t'($urandom_range(0, 3)));
    while (loads_queued < target) begin
      if ($urandom_range(0, 24) == 0) n = $urandom_range(60, 70);
      else                            n = $urandom_range(1, 16);
      if (n > target - loads_queued) n = target - loads_queued;
      queue_set(n, set_shape_t'($urandom_range(0, 3)));
    end
  endtask

  // Hold the sender until everything queued is taken and every result is back
  task automatic settle();
    while (loads_accepted != loads_queued || sorted_pending.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    running = 1'b1;

    // directed: single-element sets, extremes, duplicates, ordered runs
    push_item(32'sh7FFFFFFF, 1'b1);
    push_item(32'sh80000000, 1'b1);
    push_item(32'sh7FFFFFFF, 1'b0);
    push_item(32'sh80000000, 1'b0);
    push_item(32'sd0, 1'b0);
    push_item(-32'sd1, 1'b0);
    push_item(32'sd1, 1'b0);
    push_item(32'sh55555555, 1'b0);
    push_item(32'shAAAAAAAA, 1'b1);
    for (int k = 0; k < 4; k++) push_item(32'sd7, k == 3);
    queue_set(5, SHAPE_RISING);
    queue_set(5, SHAPE_FALLING);

    // phase 1: light sender gaps, heavy receiver stall; a full set first
    random_sets(130, CAPACITY_DEF);
    settle();

    // phase 2: roles swapped; starts with a set that overflows the store
    send_idle_pct  = 49;
    recv_stall_pct = 16;
    random_sets(255, CAPACITY_DEF + 2);
    settle();

    // phase 3: no idling; last-marked element is the one dropped
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_sets(380, CAPACITY_DEF + 1);
    settle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    running = 1'b0;

    $display("Sorted %0d sets from %0d loads, %0d results compared; largest set %0d,",
             sets_done, loads_accepted, results_seen, largest_set);
    $display("%0d sets dropped loads on a full store, %0d errors", overflow_sets, errors);
    if (errors == 0 && sorted_pending.size() == 0) begin
      $display("quicksort_sorter_unit_tb: PASS");
    end else begin
      $display("quicksort_sorter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/qss_pkg.sv
design/quicksort_sorter_unit.sv
test/quicksort_sorter_unit_tb.sv
